// ----- hw/rtl/rde_pkg.sv -----
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, operation codes and the control/status structs of the
// raster draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  localparam int unsigned SideW    = 8;                   // log2 of the maximum side
  localparam int unsigned MaxSide  = 1 << SideW;          // 256
  localparam int unsigned CoordW   = SideW + 1;           // holds 0..MaxSide
  localparam int unsigned AddrW    = 2 * SideW;           // pixel address
  localparam int unsigned Depth    = MaxSide * MaxSide;
  localparam int unsigned SpW      = AddrW + 1;           // holds 0..Depth
  localparam int unsigned ColourW  = 8;

  localparam logic [ColourW-1:0] Background = 8'd79;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PIXEL = 3'd2,
    OP_VSPAN = 3'd3,
    OP_HSPAN = 3'd4,
    OP_RECT  = 3'd5,
    OP_FLOOD = 3'd6,
    OP_READ  = 3'd7
  } op_e;

  typedef struct packed {
    logic cap;
    logic box_start;
    logic box_adv;
    logic seed_rd;
    logic seed_chk;
    logic pop;
    logic load_cur;
    logic nb_rd;
    logic nb_chk;
    logic nb_adv;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic box_empty;
    logic box_last;
    logic seed_inside;
    logic seed_same;
    logic stack_empty;
    logic nb_ok;
    logic nb_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rde_datapath.sv -----
// ----------------------------------------------------------------------------
// rde_datapath
// Frame memory, fill stack, box walker, neighbour scan and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rde_pkg::cmd_t                     cmd_i,
  output rde_pkg::status_t                       sts_o,
  input  wire logic [2:0]                        operation_i,
  input  wire logic [rde_pkg::CoordW-1:0]        x_first_i,
  input  wire logic [rde_pkg::CoordW-1:0]        y_first_i,
  input  wire logic [rde_pkg::SideW-1:0]         x_second_i,
  input  wire logic [rde_pkg::SideW-1:0]         y_second_i,
  input  wire logic [rde_pkg::ColourW-1:0]       paint_colour_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [rde_pkg::ColourW-1:0]            pixel_colour_o
);

  localparam int unsigned CW = rde_pkg::CoordW;
  localparam int unsigned SW = rde_pkg::SideW;
  localparam int unsigned AW = rde_pkg::AddrW;
  localparam logic [CW-1:0] MaxC = CW'(rde_pkg::MaxSide);

  logic [rde_pkg::ColourW-1:0] frame_mem [rde_pkg::Depth];
  logic [AW-1:0]               stack_mem [rde_pkg::Depth];

  logic [2:0]                  op_q;
  logic [CW-1:0]               xf_q, yf_q;
  logic [SW-1:0]               xs_q, ys_q;
  logic [rde_pkg::ColourW-1:0] col_q, org_q, rdata_q, pix_q;
  logic [CW-1:0]               w_q, h_q;
  logic [CW-1:0]               bx0_q, bx1_q, by1_q, cx_q, cy_q;
  logic                        bempty_q;
  logic [rde_pkg::SpW-1:0]     sp_q;
  logic [AW-1:0]               sdata_q;
  logic [1:0]                  nb_q;
  logic                        rdin_q, ovalid_q;

  // box bounds
  logic [CW-1:0] ax, bx, ay, by, x0, x1, y0, y1, x1c, y1c;
  always_comb begin
    ax = xf_q; bx = xf_q; ay = yf_q; by = yf_q;
    case (op_q)
      rde_pkg::OP_INIT, rde_pkg::OP_CLEAR: begin
        ax = '0; bx = MaxC; ay = '0; by = MaxC;
      end
      rde_pkg::OP_VSPAN: by = CW'(ys_q);
      rde_pkg::OP_HSPAN: bx = CW'(xs_q);
      rde_pkg::OP_RECT: begin
        bx = CW'(xs_q); by = CW'(ys_q);
      end
      default: ;
    endcase
    x0  = (ax < bx) ? ax : bx;
    x1  = (ax < bx) ? bx : ax;
    y0  = (ay < by) ? ay : by;
    y1  = (ay < by) ? by : ay;
    x1c = (x1 >= w_q) ? w_q - 1'b1 : x1;
    y1c = (y1 >= h_q) ? h_q - 1'b1 : y1;
  end

  // neighbour of the current pixel
  logic [CW-1:0] nx, ny;
  logic          nvalid;
  always_comb begin
    nx = cx_q; ny = cy_q; nvalid = 1'b1;
    case (nb_q)
      2'd0: nx = cx_q + 1'b1;
      2'd1: begin
        nx = cx_q - 1'b1; nvalid = (cx_q != '0);
      end
      2'd2: ny = cy_q + 1'b1;
      default: begin
        ny = cy_q - 1'b1; nvalid = (cy_q != '0);
      end
    endcase
  end

  logic [AW-1:0] seed_addr, box_addr, nb_addr, raddr, waddr;
  logic          rd_en, wr_en, push;
  assign seed_addr = {yf_q[SW-1:0], xf_q[SW-1:0]};
  assign box_addr  = {cy_q[SW-1:0], cx_q[SW-1:0]};
  assign nb_addr   = {ny[SW-1:0], nx[SW-1:0]};
  assign raddr     = cmd_i.nb_rd ? nb_addr : seed_addr;
  assign rd_en     = cmd_i.nb_rd | cmd_i.seed_rd | cmd_i.rd_issue;
  assign push      = cmd_i.seed_chk | (cmd_i.nb_chk && rdata_q == org_q);
  assign wr_en     = cmd_i.box_adv | push;
  assign waddr     = cmd_i.box_adv ? box_addr : (cmd_i.nb_chk ? nb_addr : seed_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[waddr] <= col_q;
    end
    if (rd_en) begin
      rdata_q <= frame_mem[raddr];
    end
    if (push) begin
      stack_mem[sp_q[AW-1:0]] <= waddr;
    end
    if (cmd_i.pop) begin
      sdata_q <= stack_mem[sp_q[AW-1:0] - 1'b1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q  <= operation_i;
      xf_q  <= x_first_i;
      yf_q  <= y_first_i;
      xs_q  <= x_second_i;
      ys_q  <= y_second_i;
      col_q <= (operation_i == rde_pkg::OP_INIT || operation_i == rde_pkg::OP_CLEAR)
               ? rde_pkg::Background : paint_colour_i;
    end
    if (cmd_i.box_start) begin
      bx0_q    <= x0;
      bx1_q    <= x1c;
      by1_q    <= y1c;
      cx_q     <= x0;
      cy_q     <= y0;
      bempty_q <= (w_q == '0) || (h_q == '0) || (x0 > x1c) || (y0 > y1c);
    end else if (cmd_i.box_adv) begin
      if (cx_q == bx1_q) begin
        cx_q <= bx0_q;
        cy_q <= cy_q + 1'b1;
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end else if (cmd_i.load_cur) begin
      cx_q <= CW'(sdata_q[SW-1:0]);
      cy_q <= CW'(sdata_q[AW-1:SW]);
    end
    if (cmd_i.seed_chk) begin
      org_q <= rdata_q;
    end
    if (cmd_i.rd_issue) begin
      rdin_q <= sts_o.seed_inside;
    end
    if (cmd_i.out_load) begin
      pix_q <= rdin_q ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= '0;
      h_q      <= '0;
      sp_q     <= '0;
      nb_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.cap && operation_i == rde_pkg::OP_INIT) begin
        w_q <= (x_first_i > MaxC) ? MaxC : x_first_i;
        h_q <= (y_first_i > MaxC) ? MaxC : y_first_i;
      end
      if (cmd_i.seed_chk) begin
        sp_q <= rde_pkg::SpW'(1);
      end else if (push) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_q - 1'b1;
      end
      if (cmd_i.load_cur) begin
        nb_q <= '0;
      end else if (cmd_i.nb_adv) begin
        nb_q <= nb_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op          = rde_pkg::op_e'(op_q);
  assign sts_o.box_empty   = bempty_q;
  assign sts_o.box_last    = (cx_q == bx1_q) && (cy_q == by1_q);
  assign sts_o.seed_inside = (xf_q < w_q) && (yf_q < h_q);
  assign sts_o.seed_same   = (rdata_q == col_q);
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.nb_ok       = nvalid && (nx < w_q) && (ny < h_q);
  assign sts_o.nb_last     = (nb_q == 2'd3);
  assign sts_o.out_busy    = ovalid_q && !out_ready_i;

  assign out_valid_o    = ovalid_q;
  assign pixel_colour_o = pix_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= rde_pkg::SpW'(rde_pkg::Depth))
    else $error("fill stack pointer beyond depth");
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.box_adv, cmd_i.seed_chk, cmd_i.nb_chk}))
    else $error("conflicting frame writes");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(ovalid_q && !out_ready_i))
    else $error("output word overwritten");

endmodule

`default_nettype wire

// ----- hw/rtl/rde_ctrl.sv -----
// ----------------------------------------------------------------------------
// rde_ctrl
// Command sequencer: box walk, stack driven flood fill and pixel read.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rde_pkg::status_t sts_i,
  output rde_pkg::cmd_t         cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISP     = 9'b000000010,
    S_BOX      = 9'b000000100,
    S_SEED_CHK = 9'b000001000,
    S_POP      = 9'b000010000,
    S_POPW     = 9'b000100000,
    S_NRD      = 9'b001000000,
    S_NCHK     = 9'b010000000,
    S_RD_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          rde_pkg::OP_FLOOD: begin
            if (sts_i.seed_inside) begin
              cmd_o.seed_rd = 1'b1;
              state_d       = S_SEED_CHK;
            end else begin
              state_d = S_IDLE;
            end
          end
          rde_pkg::OP_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_RD_OUT;
          end
          default: begin
            cmd_o.box_start = 1'b1;
            state_d         = S_BOX;
          end
        endcase
      end
      S_BOX: begin
        if (sts_i.box_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.box_adv = 1'b1;
          if (sts_i.box_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SEED_CHK: begin
        if (sts_i.seed_same) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.seed_chk = 1'b1;
          state_d        = S_POP;
        end
      end
      S_POP: begin
        if (sts_i.stack_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_POPW;
        end
      end
      S_POPW: begin
        cmd_o.load_cur = 1'b1;
        state_d        = S_NRD;
      end
      S_NRD: begin
        if (sts_i.nb_ok) begin
          cmd_o.nb_rd = 1'b1;
          state_d     = S_NCHK;
        end else begin
          cmd_o.nb_adv = 1'b1;
          if (sts_i.nb_last) begin
            state_d = S_POP;
          end
        end
      end
      S_NCHK: begin
        cmd_o.nb_chk = 1'b1;
        cmd_o.nb_adv = 1'b1;
        state_d      = sts_i.nb_last ? S_POP : S_NRD;
      end
      S_RD_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_cap_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> state_q == S_DISP)
    else $error("captured word not dispatched");
  a_fill_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> cmd_o.load_cur)
    else $error("popped entry not loaded");
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.nb_rd |=> cmd_o.nb_chk)
    else $error("neighbour read without check");

endmodule

`default_nettype wire

// ----- hw/rtl/raster_draw_engine.sv -----
// ----------------------------------------------------------------------------
// raster_draw_engine
// Drawing engine over a 256 x 256 x 8 bit frame: init, clear, pixel, spans,
// rectangle, flood fill and pixel read.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  words
//  in       in_valid_i / in_ready_o          input      one command
//  out      out_valid_o / out_ready_i        output     one pixel per read
//
//  box commands: capture and dispatch, then one frame write per pixel inside
//  the clipped box, or none when clipping leaves nothing
//  flood fill: each filled pixel is popped and loaded, then its neighbours
//  inside the image are read and checked in turn, those outside skipped
//  read: the pixel is read, then loaded into the output register
//  reset clears size to zero, frame contents stay undefined until drawn
//  a read waits in the engine while a previous word is not taken
// ----------------------------------------------------------------------------
`default_nettype none

module raster_draw_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [2:0]                   operation_i,
  input  wire logic [rde_pkg::CoordW-1:0]   x_first_i,
  input  wire logic [rde_pkg::CoordW-1:0]   y_first_i,
  input  wire logic [rde_pkg::SideW-1:0]    x_second_i,
  input  wire logic [rde_pkg::SideW-1:0]    y_second_i,
  input  wire logic [rde_pkg::ColourW-1:0]  paint_colour_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [rde_pkg::ColourW-1:0]       pixel_colour_o
);

  rde_pkg::cmd_t    cmd;
  rde_pkg::status_t sts;

  rde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rde_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .x_first_i      (x_first_i),
    .y_first_i      (y_first_i),
    .x_second_i     (x_second_i),
    .y_second_i     (y_second_i),
    .paint_colour_i (paint_colour_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .pixel_colour_o (pixel_colour_o)
  );

endmodule

`default_nettype wire

// ----- verif/raster_draw_engine_tb.sv -----
// ----------------------------------------------------------------------------
// raster_draw_engine_tb
// Self-checking bench for the raster draw engine. A directed table covers
// reset, oversized and empty images, clipping, spans, rectangles and flood
// fill corner cases, then random command streams run mostly on small images.
// Every read word is checked against the bench's frame predictor or a table value.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_draw_engine_tb;

  localparam int unsigned WdogLimit  = 400000;
  localparam int unsigned RandItems  = 1030;
  localparam int unsigned CalmItems  = 120;
  localparam int unsigned HoldCycles = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  logic [2:0]   operation_i = '0;
  logic [8:0]   x_first_i = '0;
  logic [8:0]   y_first_i = '0;
  logic [7:0]   x_second_i = '0;
  logic [7:0]   y_second_i = '0;
  logic [7:0]   paint_colour_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  logic [7:0]   pixel_colour_o;

  raster_draw_engine i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .x_first_i,
    .y_first_i, .x_second_i, .y_second_i, .paint_colour_i, .out_valid_o,
    .out_ready_i, .pixel_colour_o
  );

  typedef struct {
    rde_pkg::op_e op;
    logic [8:0]   xf;
    logic [8:0]   yf;
    logic [7:0]   xs;
    logic [7:0]   ys;
    logic [7:0]   col;
    bit           typed;
    logic [7:0]   pix;
  } draw_cmd_t;

  // frame model
  logic [7:0]  frame_pix [0:65535];
  bit          fill_seen [0:65535];
  int unsigned img_w, img_h;
  logic [7:0]  pixel_q [$];

  int unsigned err_cnt;
  bit          calm;
  bit          hold_req;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit in_img(int unsigned x, int unsigned y);
    return x < img_w && y < img_h;
  endfunction

  function automatic void paint_area(int unsigned xa, int unsigned ya, int unsigned xb,
                                     int unsigned yb, logic [7:0] c);
    int unsigned x0, x1, y0, y1;
    x0 = xa < xb ? xa : xb;
    x1 = xa < xb ? xb : xa;
    y0 = ya < yb ? ya : yb;
    y1 = ya < yb ? yb : ya;
    if (img_w == 0 || img_h == 0) return;
    if (x1 >= img_w) x1 = img_w - 1;
    if (y1 >= img_h) y1 = img_h - 1;
    for (int unsigned y = y0; y <= y1; y++)
      for (int unsigned x = x0; x <= x1; x++)
        if (in_img(x, y)) frame_pix[y * 256 + x] = c;
  endfunction

  function automatic void fill_probe(int unsigned x, int unsigned y, logic [7:0] org,
                                     ref int unsigned pend[$]);
    int unsigned idx;
    if (!in_img(x, y)) return;
    idx = y * 256 + x;
    if (fill_seen[idx] || frame_pix[idx] != org) return;
    fill_seen[idx] = 1'b1;
    pend = {pend, idx};
  endfunction

  function automatic void flood_region(int unsigned x, int unsigned y, logic [7:0] c);
    int unsigned pend[$];
    int unsigned idx, cx, cy;
    logic [7:0]  org;
    if (!in_img(x, y)) return;
    foreach (fill_seen[i]) fill_seen[i] = 1'b0;
    org = frame_pix[y * 256 + x];
    fill_probe(x, y, org, pend);
    while (pend.size() > 0) begin
      idx = pend.pop_back();
      cx = idx % 256;
      cy = idx / 256;
      frame_pix[idx] = c;
      fill_probe(cx + 1, cy, org, pend);
      if (cx > 0) fill_probe(cx - 1, cy, org, pend);
      fill_probe(cx, cy + 1, org, pend);
      if (cy > 0) fill_probe(cx, cy - 1, org, pend);
    end
  endfunction

  // updates the frame model, returns the read pixel for read commands
  function automatic logic [7:0] apply_cmd(draw_cmd_t d);
    case (d.op)
      rde_pkg::OP_INIT: begin
        img_w = d.xf > 256 ? 256 : d.xf;
        img_h = d.yf > 256 ? 256 : d.yf;
        paint_area(0, 0, 256, 256, rde_pkg::Background);
      end
      rde_pkg::OP_CLEAR: paint_area(0, 0, 256, 256, rde_pkg::Background);
      rde_pkg::OP_PIXEL: if (in_img(d.xf, d.yf)) frame_pix[d.yf * 256 + d.xf] = d.col;
      rde_pkg::OP_VSPAN: paint_area(d.xf, d.yf, d.xf, d.ys, d.col);
      rde_pkg::OP_HSPAN: paint_area(d.xf, d.yf, d.xs, d.yf, d.col);
      rde_pkg::OP_RECT:  paint_area(d.xf, d.yf, d.xs, d.ys, d.col);
      rde_pkg::OP_FLOOD: flood_region(d.xf, d.yf, d.col);
      default:  return in_img(d.xf, d.yf) ? frame_pix[d.yf * 256 + d.xf] : 8'd0;
    endcase
    return 8'd0;
  endfunction

  task automatic send_cmd(draw_cmd_t d);
    logic [7:0] pix;
    operation_i    <= d.op;
    x_first_i      <= d.xf;
    y_first_i      <= d.yf;
    x_second_i     <= d.xs;
    y_second_i     <= d.ys;
    paint_colour_i <= d.col;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pix = apply_cmd(d);
    if (d.op == rde_pkg::OP_READ) pixel_q = {pixel_q, (d.typed ? d.pix : pix)};
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [8:0] pick_coord(int unsigned side);
    if ($urandom_range(0, 15) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, side + 1));
  endfunction

  function automatic logic [7:0] pick_second(int unsigned side);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, side + 1));
  endfunction

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word, expected none actual %0d",
                 $time, pixel_colour_o);
        err_cnt++;
      end else begin
        if (pixel_colour_o !== pixel_q[0]) begin
          $display("%0t: pixel_colour mismatch, expected %0d actual %0d",
                   $time, pixel_q[0], pixel_colour_o);
          err_cnt++;
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any accepted word
  int unsigned quiet_cnt;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  draw_cmd_t dir_tbl [] = '{
    '{rde_pkg::OP_READ,  9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1, 8'd0},
    '{rde_pkg::OP_INIT,  9'd511, 9'd511, 8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd255, 9'd255, 8'd0,   8'd0,   8'd0,   1, 8'd79},
    '{rde_pkg::OP_READ,  9'd256, 9'd0,   8'd0,   8'd0,   8'd0,   1, 8'd0},
    '{rde_pkg::OP_PIXEL, 9'd255, 9'd255, 8'd255, 8'd255, 8'd255, 0, 8'd0},
    '{rde_pkg::OP_READ,  9'd255, 9'd255, 8'd0,   8'd0,   8'd0,   1, 8'd255},
    '{rde_pkg::OP_INIT,  9'd4,   9'd3,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd3,   9'd2,   8'd0,   8'd0,   8'd0,   1, 8'd79},
    '{rde_pkg::OP_PIXEL, 9'd4,   9'd0,   8'd0,   8'd0,   8'd1,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd4,   9'd0,   8'd0,   8'd0,   8'd0,   1, 8'd0},
    '{rde_pkg::OP_VSPAN, 9'd1,   9'd2,   8'd0,   8'd0,   8'h12,  0, 8'd0},
    '{rde_pkg::OP_HSPAN, 9'd3,   9'd0,   8'd0,   8'd0,   8'haa,  0, 8'd0},
    '{rde_pkg::OP_RECT,  9'd3,   9'd2,   8'd2,   8'd1,   8'h55,  0, 8'd0},
    '{rde_pkg::OP_FLOOD, 9'd0,   9'd1,   8'd0,   8'd0,   8'h33,  0, 8'd0},
    '{rde_pkg::OP_FLOOD, 9'd0,   9'd1,   8'd0,   8'd0,   8'h33,  0, 8'd0},
    '{rde_pkg::OP_FLOOD, 9'd9,   9'd9,   8'd0,   8'd0,   8'h77,  0, 8'd0},
    '{rde_pkg::OP_READ,  9'd0,   9'd2,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd2,   9'd1,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_CLEAR, 9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1, 8'd79},
    '{rde_pkg::OP_INIT,  9'd0,   9'd5,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_PIXEL, 9'd0,   9'd0,   8'd0,   8'd0,   8'd9,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1, 8'd0},
    '{rde_pkg::OP_INIT,  9'd8,   9'd8,   8'd0,   8'd0,   8'd0,   0, 8'd0},
    '{rde_pkg::OP_READ,  9'd7,   9'd7,   8'd0,   8'd0,   8'd0,   1, 8'd79}
  };

  initial begin
    draw_cmd_t   d;
    int unsigned big_left;
    int unsigned sel;
    int unsigned drain;
    err_cnt  = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    big_left = 0;
    img_w    = 0;
    img_h    = 0;
    foreach (frame_pix[i]) frame_pix[i] = 8'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_cmd(dir_tbl[i]);

    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n == 40) hold_req = 1'b1;
      if (n == RandItems - CalmItems) calm = 1'b1;
      d = '{rde_pkg::OP_READ, 9'd0, 9'd0, 8'd0, 8'd0, 8'd0, 0, 8'd0};
      sel = $urandom_range(0, 99);
      if (big_left == 1) begin
        d.op = rde_pkg::OP_INIT;
      end else if (sel < 6) begin
        d.op = rde_pkg::OP_INIT;
      end else if (sel < 9) begin
        d.op = big_left > 0 ? rde_pkg::OP_READ : rde_pkg::OP_CLEAR;
      end else if (sel < 20) begin
        d.op = rde_pkg::OP_PIXEL;
      end else if (sel < 29) begin
        d.op = rde_pkg::OP_VSPAN;
      end else if (sel < 38) begin
        d.op = rde_pkg::OP_HSPAN;
      end else if (sel < 48) begin
        d.op = rde_pkg::OP_RECT;
      end else if (sel < 60) begin
        d.op = big_left > 0 ? rde_pkg::OP_PIXEL : rde_pkg::OP_FLOOD;
      end
      if (d.op == rde_pkg::OP_INIT) begin
        if (big_left == 0 && $urandom_range(0, 15) == 0) begin
          d.xf = 9'($urandom_range(200, 511));
          d.yf = 9'($urandom_range(200, 511));
          big_left = 8;
        end else begin
          d.xf = 9'($urandom_range(0, 16));
          d.yf = 9'($urandom_range(0, 16));
          big_left = 0;
        end
      end else begin
        d.xf = pick_coord(img_w);
        d.yf = pick_coord(img_h);
        d.xs = pick_second(img_w);
        d.ys = pick_second(img_h);
        if (big_left > 0 && d.op == rde_pkg::OP_RECT) begin
          d.xs = 8'(d.xf[7:0] + $urandom_range(0, 20));
          d.ys = 8'(d.yf[7:0] + $urandom_range(0, 20));
        end
        // few colours so flood regions stay connected
        d.col = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 3));
        if (big_left > 0) big_left--;
      end
      send_cmd(d);
    end
    in_valid_i <= 1'b0;

    while (pixel_q.size() > 0) @(posedge clk_i);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
